// ===== rtl/core/explicit_diffusion_step_1d_assert.svh =====
// Assertion macros for the diffusion step block
`ifndef EXPLICIT_DIFFUSION_STEP_1D_ASSERT_SVH
`define EXPLICIT_DIFFUSION_STEP_1D_ASSERT_SVH
`ifndef ASSERT_OFF
`define EDS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("explicit_diffusion_step_1d: same-cycle check failed");
`define EDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("explicit_diffusion_step_1d: next-cycle check failed");
`else
`define EDS_ASSERT_IMPL(label, ante, cons)
`define EDS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/eds_pkg.sv =====
// Shared types and constants of the diffusion step block
package eds_pkg;

  localparam int ACC_W   = 128;
  localparam int CAND_W  = 36;
  localparam int PADDR_W = 5;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_NEGATIVE = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [2:0] REG_ACTIVE_NODES = 3'd0;
  localparam logic [2:0] REG_LEFT_DIR     = 3'd1;
  localparam logic [2:0] REG_RIGHT_DIR    = 3'd2;
  localparam logic [2:0] REG_LEFT_BV      = 3'd3;
  localparam logic [2:0] REG_RIGHT_BV     = 3'd4;
  localparam logic [2:0] REG_LEFT_D       = 3'd5;
  localparam logic [2:0] REG_RIGHT_D      = 3'd6;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  node_index;
    logic [31:0] load_concentration;
    logic [31:0] load_face_conductance;
    logic [31:0] load_inverse_volume;
    logic [31:0] time_step;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] node_concentration_out;
  } rsp_t;

  typedef struct packed {
    logic [6:0]         active_nodes;
    logic               left_is_dirichlet;
    logic               right_is_dirichlet;
    logic signed [31:0] left_boundary_value;
    logic signed [31:0] right_boundary_value;
    logic [31:0]        left_end_diffusivity;
    logic [31:0]        right_end_diffusivity;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic        clr;
    logic [1:0]  sh;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } mac_op_t;

endpackage

// ===== rtl/core/eds_cfg.sv =====
// APB configuration registers
module eds_cfg import eds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_nodes          <= 7'd64;
      cfg.left_is_dirichlet     <= 1'b0;
      cfg.right_is_dirichlet    <= 1'b0;
      cfg.left_boundary_value   <= '0;
      cfg.right_boundary_value  <= '0;
      cfg.left_end_diffusivity  <= '0;
      cfg.right_end_diffusivity <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ACTIVE_NODES: cfg.active_nodes          <= pwdata[6:0];
        REG_LEFT_DIR:     cfg.left_is_dirichlet     <= pwdata[0];
        REG_RIGHT_DIR:    cfg.right_is_dirichlet    <= pwdata[0];
        REG_LEFT_BV:      cfg.left_boundary_value   <= pwdata;
        REG_RIGHT_BV:     cfg.right_boundary_value  <= pwdata;
        REG_LEFT_D:       cfg.left_end_diffusivity  <= pwdata;
        REG_RIGHT_D:      cfg.right_end_diffusivity <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ACTIVE_NODES: prdata = 32'(cfg.active_nodes);
      REG_LEFT_DIR:     prdata = 32'(cfg.left_is_dirichlet);
      REG_RIGHT_DIR:    prdata = 32'(cfg.right_is_dirichlet);
      REG_LEFT_BV:      prdata = cfg.left_boundary_value;
      REG_RIGHT_BV:     prdata = cfg.right_boundary_value;
      REG_LEFT_D:       prdata = cfg.left_end_diffusivity;
      REG_RIGHT_D:      prdata = cfg.right_end_diffusivity;
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/eds_mac.sv =====
// Shared 32x32 multiplier with shifted 128-bit accumulator
module eds_mac import eds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mac_op_t          op,
  output logic [ACC_W-1:0] acc
);

  logic [63:0]      prod;
  logic             p_en;
  logic             p_clr;
  logic [1:0]       p_sh;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_en <= 1'b0;
    end else begin
      p_en <= op.en;
    end
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod  <= 64'(op.op_a) * 64'(op.op_b);
      p_clr <= op.clr;
      p_sh  <= op.sh;
    end
    if (p_en) begin
      acc <= base + addend;
    end
  end

  always_comb begin
    base = p_clr ? '0 : acc;
    case (p_sh)
      SH_32:   addend = ACC_W'(prod) << 32;
      SH_64:   addend = ACC_W'(prod) << 64;
      default: addend = ACC_W'(prod);
    endcase
  end

endmodule

// ===== rtl/core/explicit_diffusion_step_1d.sv =====
// Top level: node stores and step sequencer of the 1-D explicit diffusion block
//
// channel | handshake                  | payload
// req     | req_valid / req_ready      | req (req_t): opcode, node, load values, time step
// rsp     | rsp_valid / rsp_ready      | rsp (rsp_t): status, node concentration
// apb     | psel, penable / pready     | paddr, pwrite, pwdata, prdata
//
// Load and unused opcode go from idle straight to the result stage; read passes
// through a read-wait stage first. Step (nonzero time step) runs a stability pass
// over the free nodes, an update pass over interior and free end nodes, then commits
// every node. One shared 32x32 multiplier serves all products; each store has one
// read port. rst is synchronous and clears control and config; the node stores hold
// garbage until loaded. req_ready is low while an item is at work; a held result in
// the output register does not stop the next accept.
`include "explicit_diffusion_step_1d_assert.svh"
module explicit_diffusion_step_1d import eds_pkg::*; #(
  parameter int MAX_NODES    = 64,
  parameter int ROUNDOFF_LSB = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NW = (CW > 7) ? CW : 7;
  localparam logic signed [CAND_W-1:0] NEG_LIM = CAND_W'(-ROUNDOFF_LSB);

  typedef enum logic [30:0] {
    ST_IDLE    = 31'd1 << 0,
    ST_RD_WAIT = 31'd1 << 1,
    ST_DONE    = 31'd1 << 2,
    ST_N_I     = 31'd1 << 3,
    ST_N_L     = 31'd1 << 4,
    ST_N_R     = 31'd1 << 5,
    ST_N_A     = 31'd1 << 6,
    ST_C_M0    = 31'd1 << 7,
    ST_C_M1    = 31'd1 << 8,
    ST_C_M2    = 31'd1 << 9,
    ST_C_M3    = 31'd1 << 10,
    ST_C_W     = 31'd1 << 11,
    ST_C_EV    = 31'd1 << 12,
    ST_F_K0    = 31'd1 << 13,
    ST_F_K1    = 31'd1 << 14,
    ST_F_KW    = 31'd1 << 15,
    ST_F_P0    = 31'd1 << 16,
    ST_F_P1    = 31'd1 << 17,
    ST_F_PW    = 31'd1 << 18,
    ST_F_ACC   = 31'd1 << 19,
    ST_B_M     = 31'd1 << 20,
    ST_B_W     = 31'd1 << 21,
    ST_B_P0    = 31'd1 << 22,
    ST_B_P1    = 31'd1 << 23,
    ST_B_P2    = 31'd1 << 24,
    ST_B_P3    = 31'd1 << 25,
    ST_B_PW    = 31'd1 << 26,
    ST_B_ACC   = 31'd1 << 27,
    ST_FIN     = 31'd1 << 28,
    ST_CP_RD   = 31'd1 << 29,
    ST_CP_WR   = 31'd1 << 30
  } state_t;

  cfg_t             cfg;
  mac_op_t          mop;
  logic [ACC_W-1:0] acc;

  eds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eds_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .acc (acc)
  );

  logic [31:0] conc_mem [MAX_NODES];
  logic [31:0] next_mem [MAX_NODES];
  logic [31:0] cond_mem [MAX_NODES];
  logic [31:0] invv_mem [MAX_NODES];

  state_t                    state;
  logic [AW-1:0]             node;
  logic                      upd;
  logic                      side;
  logic                      ovf;
  logic                      neg;
  logic                      rd_ok;
  logic [31:0]               dt;
  logic [31:0]               c_i;
  logic [31:0]               c_l;
  logic [31:0]               c_r;
  logic [31:0]               g_l;
  logic [31:0]               g_r;
  logic [63:0]               a;
  logic [63:0]               m;
  logic signed [CAND_W-1:0]  cand;
  logic [1:0]                res_status;
  logic [31:0]               res_value;
  logic [31:0]               conc_q;
  logic [31:0]               next_q;
  logic [31:0]               cond_q;
  logic [31:0]               invv_q;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             raddr_q;

  logic [NW-1:0]             an_w;
  logic [NW-1:0]             n_w;
  logic [CW-1:0]             n;
  logic [AW-1:0]             last;
  logic                      at_left;
  logic                      at_right;
  logic                      fixed;
  logic [31:0]               fix_val;
  logic [31:0]               rd_val;
  logic                      idx_ok;
  logic                      load_we;
  logic [31:0]               g_sel;
  logic [31:0]               c_nb;
  logic                      mneg;
  logic [31:0]               mag;
  logic [32:0]               r;
  logic signed [CAND_W-1:0]  rs;
  logic [31:0]               bv_sel;
  logic [31:0]               d_sel;
  logic                      bneg;
  logic [31:0]               bmag;
  logic [32:0]               v;
  logic signed [CAND_W-1:0]  vs;
  logic                      b_ovf;
  logic                      chk_fail;
  logic                      fin_ovf;
  logic                      fin_neg;
  logic [31:0]               fin_val;
  logic                      ovf_any;
  logic                      neg_any;
  logic                      advance;
  state_t                    adv_next;
  logic [AW-1:0]             adv_node;
  logic [1:0]                adv_status;

  function automatic logic [31:0] dir_val(input logic [31:0] bv);
    return bv[31] ? 32'd0 : bv;
  endfunction

  always_comb begin
    an_w = NW'(cfg.active_nodes);
    if (an_w < NW'(2)) begin
      n_w = NW'(2);
    end else if (an_w > NW'(MAX_NODES)) begin
      n_w = NW'(MAX_NODES);
    end else begin
      n_w = an_w;
    end
  end

  assign n        = CW'(n_w);
  assign last     = AW'(n - CW'(1));
  assign at_left  = (node == '0);
  assign at_right = (node == last);
  assign fixed    = (at_left && cfg.left_is_dirichlet) || (at_right && cfg.right_is_dirichlet);
  assign fix_val  = (at_left && cfg.left_is_dirichlet) ? dir_val(cfg.left_boundary_value)
                                                       : dir_val(cfg.right_boundary_value);
  assign idx_ok   = (32'(req.node_index) < 32'(MAX_NODES));
  assign load_we  = (state == ST_IDLE) && req_valid && (req.opcode == OP_LOAD) && idx_ok;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    if (raddr_q == '0 && cfg.left_is_dirichlet) begin
      rd_val = dir_val(cfg.left_boundary_value);
    end else if (raddr_q == last && cfg.right_is_dirichlet) begin
      rd_val = dir_val(cfg.right_boundary_value);
    end else begin
      rd_val = conc_q;
    end
  end

  // face term datapath
  assign g_sel = side ? g_r : g_l;
  assign c_nb  = side ? c_r : c_l;
  assign mneg  = (c_nb < c_i);
  assign mag   = mneg ? (c_i - c_nb) : (c_nb - c_i);
  assign r     = {1'b0, acc[63:32]} + 33'(acc[31]);
  assign rs    = $signed(CAND_W'(r));

  // gradient boundary term
  assign bv_sel = at_left ? cfg.left_boundary_value : cfg.right_boundary_value;
  assign d_sel  = at_left ? cfg.left_end_diffusivity : cfg.right_end_diffusivity;
  assign bneg   = bv_sel[31];
  assign bmag   = bneg ? (~bv_sel + 32'd1) : bv_sel;
  assign v      = {1'b0, acc[87:56]} + 33'(acc[55]);
  assign vs     = $signed(CAND_W'(v));
  assign b_ovf  = |acc[127:88];

  assign chk_fail = (|acc[127:57]) || (acc[56] && (|acc[55:0]));

  assign fin_ovf = !cand[CAND_W-1] && (|cand[CAND_W-2:32]);
  assign fin_neg = (cand < NEG_LIM);
  assign fin_val = (cand[CAND_W-1] || fin_ovf) ? 32'd0 : cand[31:0];

  assign ovf_any = ovf || ((state == ST_FIN) && fin_ovf);
  assign neg_any = neg || ((state == ST_FIN) && fin_neg);
  assign advance = ((state == ST_N_I) && fixed) || ((state == ST_C_EV) && !chk_fail) ||
                   (state == ST_FIN);
  assign adv_node = at_right ? '0 : node + AW'(1);

  always_comb begin
    if (!at_right || !upd) begin
      adv_next = ST_N_I;
    end else if (ovf_any || neg_any) begin
      adv_next = ST_DONE;
    end else begin
      adv_next = ST_CP_RD;
    end
    if (ovf_any) begin
      adv_status = STATUS_OVERFLOW;
    end else if (neg_any) begin
      adv_status = STATUS_NEGATIVE;
    end else begin
      adv_status = STATUS_OK;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: raddr = AW'(req.node_index);
      ST_N_L:  raddr = node - AW'(1);
      ST_N_R:  raddr = at_right ? node : node + AW'(1);
      default: raddr = node;
    endcase
  end

  always_comb begin
    mop = '0;
    case (state)
      ST_N_L:  mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: dt,        op_b: invv_q};
      ST_C_M0: mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: a[31:0],   op_b: g_l};
      ST_C_M1: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: a[63:32],  op_b: g_l};
      ST_C_M2: mop = '{en: 1'b1, clr: 1'b0, sh: SH_0,  op_a: a[31:0],   op_b: g_r};
      ST_C_M3: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: a[63:32],  op_b: g_r};
      ST_F_K0: mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: a[31:0],   op_b: g_sel};
      ST_F_K1: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: a[63:32],  op_b: g_sel};
      ST_F_P0: mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: acc[55:24], op_b: mag};
      ST_F_P1: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: 32'(acc[56]), op_b: mag};
      ST_B_M:  mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: d_sel,     op_b: bmag};
      ST_B_P0: mop = '{en: 1'b1, clr: 1'b1, sh: SH_0,  op_a: a[31:0],   op_b: acc[31:0]};
      ST_B_P1: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: a[31:0],   op_b: m[63:32]};
      ST_B_P2: mop = '{en: 1'b1, clr: 1'b0, sh: SH_32, op_a: a[63:32],  op_b: m[31:0]};
      ST_B_P3: mop = '{en: 1'b1, clr: 1'b0, sh: SH_64, op_a: a[63:32],  op_b: m[63:32]};
      default: mop = '0;
    endcase
  end

  // node stores
  always_ff @(posedge clk) begin
    if (load_we) begin
      conc_mem[AW'(req.node_index)] <= req.load_concentration;
      cond_mem[AW'(req.node_index)] <= req.load_face_conductance;
      invv_mem[AW'(req.node_index)] <= req.load_inverse_volume;
    end else if (state == ST_CP_WR) begin
      conc_mem[node] <= next_q;
    end
    if (state == ST_FIN) begin
      next_mem[node] <= fin_val;
    end else if ((state == ST_N_I) && fixed && upd) begin
      next_mem[node] <= fix_val;
    end
    conc_q  <= conc_mem[raddr];
    next_q  <= next_mem[raddr];
    cond_q  <= cond_mem[raddr];
    invv_q  <= invv_mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            res_status <= STATUS_OK;
            res_value  <= '0;
            dt         <= req.time_step;
            node       <= '0;
            upd        <= 1'b0;
            ovf        <= 1'b0;
            neg        <= 1'b0;
            rd_ok      <= idx_ok;
            case (req.opcode)
              OP_STEP: begin
                if (req.time_step == '0) begin
                  res_status <= STATUS_INVALID;
                  state      <= ST_DONE;
                end else begin
                  state <= ST_N_I;
                end
              end
              OP_READ: state <= ST_RD_WAIT;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          if (rd_ok) begin
            res_value <= rd_val;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: res_status, node_concentration_out: res_value};
            state     <= ST_IDLE;
          end
        end
        ST_N_I: begin
          if (!fixed) begin
            state <= ST_N_L;
          end
        end
        ST_N_L: begin
          c_i   <= rd_val;
          g_r   <= at_right ? 32'd0 : cond_q;
          state <= ST_N_R;
        end
        ST_N_R: begin
          c_l   <= rd_val;
          g_l   <= at_left ? 32'd0 : cond_q;
          state <= ST_N_A;
        end
        ST_N_A: begin
          c_r  <= rd_val;
          a    <= acc[63:0];
          cand <= $signed(CAND_W'(c_i));
          if (!upd) begin
            state <= ST_C_M0;
          end else begin
            side  <= at_left;
            state <= ST_F_K0;
          end
        end
        ST_C_M0: state <= ST_C_M1;
        ST_C_M1: state <= ST_C_M2;
        ST_C_M2: state <= ST_C_M3;
        ST_C_M3: state <= ST_C_W;
        ST_C_W:  state <= ST_C_EV;
        ST_C_EV: begin
          if (chk_fail) begin
            res_status <= STATUS_INVALID;
            state      <= ST_DONE;
          end
        end
        ST_F_K0: state <= ST_F_K1;
        ST_F_K1: state <= ST_F_KW;
        ST_F_KW: state <= ST_F_P0;
        ST_F_P0: state <= ST_F_P1;
        ST_F_P1: state <= ST_F_PW;
        ST_F_PW: state <= ST_F_ACC;
        ST_F_ACC: begin
          cand <= mneg ? (cand - rs) : (cand + rs);
          if (!side && !at_right) begin
            side  <= 1'b1;
            state <= ST_F_K0;
          end else if (at_left || at_right) begin
            state <= ST_B_M;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_B_M: state <= ST_B_W;
        ST_B_W: state <= ST_B_P0;
        ST_B_P0: begin
          m     <= acc[63:0];
          state <= ST_B_P1;
        end
        ST_B_P1: state <= ST_B_P2;
        ST_B_P2: state <= ST_B_P3;
        ST_B_P3: state <= ST_B_PW;
        ST_B_PW: state <= ST_B_ACC;
        ST_B_ACC: begin
          if (b_ovf) begin
            ovf <= 1'b1;
          end else begin
            cand <= bneg ? (cand - vs) : (cand + vs);
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          ovf <= ovf_any;
          neg <= neg_any;
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          if (at_right) begin
            state <= ST_DONE;
          end else begin
            node  <= node + AW'(1);
            state <= ST_CP_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (advance) begin
        node       <= adv_node;
        state      <= adv_next;
        res_status <= adv_status;
        if (at_right && !upd) begin
          upd <= 1'b1;
        end
      end
    end
  end

  `EDS_ASSERT_IMPL(a_copy_clean, state == ST_CP_RD, !ovf && !neg)
  `EDS_ASSERT_IMPL(a_node_range, state == ST_FIN, CW'(node) < n)
  `EDS_ASSERT_NEXT(a_dt_zero, req_valid && req_ready && req.opcode == OP_STEP && req.time_step == '0, state == ST_DONE && res_status == STATUS_INVALID)

endmodule
